>>> rtl/core/joystick_to_velocity_mapper_defines.svh
// Assertion helpers used by the mapping stage, jvm_back.sv.
`ifndef JOYSTICK_TO_VELOCITY_MAPPER_DEFINES_SVH
`define JOYSTICK_TO_VELOCITY_MAPPER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define JVM_ASSERT_IMP(LBL, CLK, RST_N, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication, checked on every rising edge outside reset.
`define JVM_ASSERT_NXT(LBL, CLK, RST_N, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RST_N) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

>>> rtl/core/jvm_pkg.sv
package jvm_pkg;

  localparam int AXIS_W     = 12;
  localparam int KIND_W     = 8;
  localparam int SPD_W      = 15;
  localparam int Q_W        = 16;
  localparam int VEL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int N_AXIS     = 3;
  localparam int N_LANE     = 4;
  localparam int SQ_W       = 2 * Q_W;
  localparam int PROD_W     = Q_W + SPD_W;

  // Lane order through the divider
  localparam int LANE_X   = 0;
  localparam int LANE_Y   = 1;
  localparam int LANE_ROT = 2;
  localparam int LANE_DB  = 3;

  localparam logic [KIND_W-1:0] KIND_DISCRETE = 8'd2;
  localparam logic [KIND_W-1:0] KIND_PROP     = 8'd3;

  localparam logic [AXIS_W-1:0] CENTER_RST   = 12'd1700;
  localparam logic [AXIS_W-1:0] DEADBAND_RST = 12'd200;
  localparam logic [SPD_W-1:0]  MAX_LIN_RST  = 15'd256;
  localparam logic [SPD_W-1:0]  MAX_ANG_RST  = 15'd256;

  localparam logic [Q_W-1:0] Q_ONE  = 16'h8000;
  localparam logic [Q_W-1:0] Q_MAX  = 16'h7FFF;
  localparam logic [Q_W-1:0] DB_SAT = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER   = 2'd0,
    CFG_DEADBAND = 2'd1,
    CFG_MAX_LIN  = 2'd2,
    CFG_MAX_ANG  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_DISC = 2'd1,
    MODE_PROP = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [N_AXIS-1:0] neg;
  } side_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_turn;
    logic signed [VEL_W-1:0] vel_lateral;
    logic signed [VEL_W-1:0] vel_forward;
  } vel_t;

endpackage

>>> rtl/core/joystick_to_velocity_mapper.sv
// Pipeline: 20 register stages (1 front, 16 divider, 3 mapping).
// Throughput: one transaction per cycle while out_tready is high; the 16-stage radix-2
//   divider retires one quotient bit per stage for all four lanes, so a new transaction enters every cycle.
// Reset: synchronous, active-low rst_n clears all valid bits and loads register defaults
//   (center 1700, deadband 200, both speed limits 256); no clearing pass is needed.
module joystick_to_velocity_mapper #(
  parameter int ADC_FULL_SCALE = 4095
) (
  input  logic                              clk,
  input  logic                              rst_n,

  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [11:0] stick_x, [23:12] stick_y, [35:24] stick_rot, [39:36] zero
  input  logic [39:0]                       in_tdata,
  // [7:0] kind
  input  logic [jvm_pkg::KIND_W-1:0]        in_tuser,

  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] vel_forward, [31:16] vel_lateral, [47:32] vel_turn
  output logic [47:0]                       out_tdata,

  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jvm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Divisors are the clamped center or full scale minus it; both fit in DEN_W bits,
  // never narrower than a raw reading.
  localparam int DEN_W = ($clog2(ADC_FULL_SCALE) > jvm_pkg::AXIS_W) ?
                         $clog2(ADC_FULL_SCALE) : jvm_pkg::AXIS_W;

  // Configuration registers
  logic [jvm_pkg::AXIS_W-1:0] center_r;
  logic [jvm_pkg::AXIS_W-1:0] deadband_r;
  logic [jvm_pkg::SPD_W-1:0]  max_lin_r;
  logic [jvm_pkg::SPD_W-1:0]  max_ang_r;

  // Front to divider
  logic                                                 fr_valid, fr_ready;
  logic [jvm_pkg::N_LANE-1:0][jvm_pkg::AXIS_W-1:0]      fr_num;
  logic [jvm_pkg::N_LANE-1:0][DEN_W-1:0]                fr_den;
  logic [jvm_pkg::N_LANE-1:0]                           fr_big;
  jvm_pkg::side_t                                       fr_side;

  // Divider to mapping
  logic                                                 dv_valid, dv_ready;
  logic [jvm_pkg::N_LANE-1:0][jvm_pkg::Q_W-1:0]         dv_quo;
  logic [jvm_pkg::N_LANE-1:0]                           dv_big;
  jvm_pkg::side_t                                       dv_side;

  jvm_pkg::vel_t                                        vel;

  // Writes are always taken; the user keeps the block idle whenever software writes; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r   <= jvm_pkg::CENTER_RST;
      deadband_r <= jvm_pkg::DEADBAND_RST;
      max_lin_r  <= jvm_pkg::MAX_LIN_RST;
      max_ang_r  <= jvm_pkg::MAX_ANG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (jvm_pkg::cfg_idx_t'(cfg_index))
        jvm_pkg::CFG_CENTER:   center_r   <= cfg_data[jvm_pkg::AXIS_W-1:0];
        jvm_pkg::CFG_DEADBAND: deadband_r <= cfg_data[jvm_pkg::AXIS_W-1:0];
        jvm_pkg::CFG_MAX_LIN:  max_lin_r  <= cfg_data;
        jvm_pkg::CFG_MAX_ANG:  max_ang_r  <= cfg_data;
      endcase
    end
  end

  // Offset each axis from the clamped center, pick its divisor and flag
  // quotients that would overflow 16 bits; the deadband rides along as a fourth lane.
  jvm_front #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE),
    .DEN_W          (DEN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (in_tvalid),
    .s_ready   (in_tready),
    .kind      (in_tuser),
    .stick_x   (in_tdata[11:0]),
    .stick_y   (in_tdata[23:12]),
    .stick_rot (in_tdata[35:24]),
    .center    (center_r),
    .deadband  (deadband_r),
    .m_valid   (fr_valid),
    .m_ready   (fr_ready),
    .num       (fr_num),
    .den       (fr_den),
    .big       (fr_big),
    .side      (fr_side)
  );

  // Normalize to Q1.15: offset * 2^15 / divisor, one quotient bit per stage.
  jvm_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (fr_valid),
    .s_ready (fr_ready),
    .num     (fr_num),
    .den     (fr_den),
    .big     (fr_big),
    .side    (fr_side),
    .m_valid (dv_valid),
    .m_ready (dv_ready),
    .quo     (dv_quo),
    .m_big   (dv_big),
    .m_side  (dv_side)
  );

  // Saturate, apply the deadband tests and scale by the speed limits; the last
  // stage is the output register, so a stalled result never blocks earlier stages
  // that still have room.
  jvm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (dv_valid),
    .s_ready (dv_ready),
    .quo     (dv_quo),
    .big     (dv_big),
    .side    (dv_side),
    .max_lin (max_lin_r),
    .max_ang (max_ang_r),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .vel     (vel)
  );

  assign out_tdata = vel;

endmodule

>>> rtl/core/jvm_front.sv
module jvm_front #(
  parameter int ADC_FULL_SCALE = 4095,
  parameter int DEN_W          = 12
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    s_valid,
  output logic                                                    s_ready,
  input  logic [jvm_pkg::KIND_W-1:0]                              kind,
  input  logic [jvm_pkg::AXIS_W-1:0]                              stick_x,
  input  logic [jvm_pkg::AXIS_W-1:0]                              stick_y,
  input  logic [jvm_pkg::AXIS_W-1:0]                              stick_rot,
  input  logic [jvm_pkg::AXIS_W-1:0]                              center,
  input  logic [jvm_pkg::AXIS_W-1:0]                              deadband,
  output logic                                                    m_valid,
  input  logic                                                    m_ready,
  output logic [jvm_pkg::N_LANE-1:0][jvm_pkg::AXIS_W-1:0]         num,
  output logic [jvm_pkg::N_LANE-1:0][DEN_W-1:0]                   den,
  output logic [jvm_pkg::N_LANE-1:0]                              big,
  output jvm_pkg::side_t                                          side
);

  localparam logic [DEN_W:0] FS    = (DEN_W + 1)'(ADC_FULL_SCALE);
  localparam logic [DEN_W:0] C_MAX = (DEN_W + 1)'(ADC_FULL_SCALE - 1);
  localparam logic [DEN_W:0] C_MIN = (DEN_W + 1)'(1);

  logic [DEN_W:0]                                   ctr;
  logic [DEN_W:0]                                   c_eff;
  logic [DEN_W:0]                                   pos_den;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::AXIS_W-1:0]  axis_raw;
  logic [jvm_pkg::N_AXIS-1:0][DEN_W:0]              raw_ext;
  logic [jvm_pkg::N_LANE-1:0][DEN_W:0]              d_ext;
  logic [jvm_pkg::N_LANE-1:0][DEN_W:0]              den_ext;

  logic [jvm_pkg::N_LANE-1:0][jvm_pkg::AXIS_W-1:0]  num_nxt;
  logic [jvm_pkg::N_LANE-1:0][DEN_W-1:0]            den_nxt;
  logic [jvm_pkg::N_LANE-1:0]                       big_nxt;
  jvm_pkg::side_t                                   side_nxt;

  logic                                             vld_r;
  logic [jvm_pkg::N_LANE-1:0][jvm_pkg::AXIS_W-1:0]  num_r;
  logic [jvm_pkg::N_LANE-1:0][DEN_W-1:0]            den_r;
  logic [jvm_pkg::N_LANE-1:0]                       big_r;
  jvm_pkg::side_t                                   side_r;
  logic                                             rdy;

  assign axis_raw[jvm_pkg::LANE_X]   = stick_x;
  assign axis_raw[jvm_pkg::LANE_Y]   = stick_y;
  assign axis_raw[jvm_pkg::LANE_ROT] = stick_rot;

  always_comb begin
    // Clamp the center so neither divisor can reach zero
    ctr = (DEN_W + 1)'(center);
    if (ctr < C_MIN) begin
      c_eff = C_MIN;
    end else if (ctr > C_MAX) begin
      c_eff = C_MAX;
    end else begin
      c_eff = ctr;
    end
    pos_den = FS - c_eff;

    side_nxt.neg = '0;
    for (int i = 0; i < jvm_pkg::N_AXIS; i++) begin
      raw_ext[i]      = (DEN_W + 1)'(axis_raw[i]);
      side_nxt.neg[i] = raw_ext[i] < c_eff;
      if (side_nxt.neg[i]) begin
        d_ext[i]   = c_eff - raw_ext[i];
        den_ext[i] = c_eff;
      end else begin
        d_ext[i]   = raw_ext[i] - c_eff;
        den_ext[i] = pos_den;
      end
    end
    d_ext[jvm_pkg::LANE_DB]   = (DEN_W + 1)'(deadband);
    den_ext[jvm_pkg::LANE_DB] = c_eff;

    // Quotient of d * 2^15 / den reaches 2^16 exactly when d >= 2 * den
    for (int l = 0; l < jvm_pkg::N_LANE; l++) begin
      big_nxt[l] = d_ext[l] >= {den_ext[l][DEN_W-1:0], 1'b0};
      num_nxt[l] = d_ext[l][jvm_pkg::AXIS_W-1:0];
      den_nxt[l] = den_ext[l][DEN_W-1:0];
    end

    unique case (kind)
      jvm_pkg::KIND_DISCRETE: side_nxt.mode = jvm_pkg::MODE_DISC;
      jvm_pkg::KIND_PROP:     side_nxt.mode = jvm_pkg::MODE_PROP;
      default:                side_nxt.mode = jvm_pkg::MODE_ZERO;
    endcase
  end

  assign rdy     = !vld_r || m_ready;
  assign s_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && s_valid) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      big_r  <= big_nxt;
      side_r <= side_nxt;
    end
  end

  assign m_valid = vld_r;
  assign num     = num_r;
  assign den     = den_r;
  assign big     = big_r;
  assign side    = side_r;

endmodule

>>> rtl/core/jvm_div.sv
module jvm_div #(
  parameter int DEN_W = 12
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                s_valid,
  output logic                                                s_ready,
  input  logic [jvm_pkg::N_LANE-1:0][jvm_pkg::AXIS_W-1:0]     num,
  input  logic [jvm_pkg::N_LANE-1:0][DEN_W-1:0]               den,
  input  logic [jvm_pkg::N_LANE-1:0]                          big,
  input  jvm_pkg::side_t                                      side,
  output logic                                                m_valid,
  input  logic                                                m_ready,
  output logic [jvm_pkg::N_LANE-1:0][jvm_pkg::Q_W-1:0]        quo,
  output logic [jvm_pkg::N_LANE-1:0]                          m_big,
  output jvm_pkg::side_t                                      m_side
);

  // One quotient bit per stage, most significant first
  localparam int NSTEP = jvm_pkg::Q_W;

  logic [NSTEP-1:0]                                  vld_r;
  logic [jvm_pkg::N_LANE-1:0][DEN_W:0]               rem_r  [NSTEP];
  logic [jvm_pkg::N_LANE-1:0][DEN_W-1:0]             den_r  [NSTEP];
  logic [jvm_pkg::N_LANE-1:0][jvm_pkg::Q_W-1:0]      q_r    [NSTEP];
  logic [jvm_pkg::N_LANE-1:0]                        big_r  [NSTEP];
  jvm_pkg::side_t                                    side_r [NSTEP];
  logic [NSTEP:0]                                    rdy;

  assign rdy[NSTEP] = m_ready;

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic                                             vld_in;
    logic [jvm_pkg::N_LANE-1:0][DEN_W:0]              rem_in;
    logic [jvm_pkg::N_LANE-1:0][DEN_W-1:0]            den_in;
    logic [jvm_pkg::N_LANE-1:0][jvm_pkg::Q_W-1:0]     q_in;
    logic [jvm_pkg::N_LANE-1:0]                       big_in;
    jvm_pkg::side_t                                   side_in;
    logic [jvm_pkg::N_LANE-1:0]                       ge;
    logic [jvm_pkg::N_LANE-1:0][DEN_W:0]              rem_nxt;
    logic [jvm_pkg::N_LANE-1:0][jvm_pkg::Q_W-1:0]     q_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = s_valid;
      assign den_in  = den;
      assign big_in  = big;
      assign side_in = side;
      assign q_in    = '0;
      always_comb begin
        for (int l = 0; l < jvm_pkg::N_LANE; l++) begin
          rem_in[l] = (DEN_W + 1)'(num[l]);
        end
      end
    end else begin : g_rest
      assign vld_in  = vld_r[k-1];
      assign den_in  = den_r[k-1];
      assign big_in  = big_r[k-1];
      assign side_in = side_r[k-1];
      assign q_in    = q_r[k-1];
      always_comb begin
        for (int l = 0; l < jvm_pkg::N_LANE; l++) begin
          rem_in[l] = {rem_r[k-1][l][DEN_W-1:0], 1'b0};
        end
      end
    end

    // Restoring step: subtract when the partial remainder covers the divisor
    always_comb begin
      for (int l = 0; l < jvm_pkg::N_LANE; l++) begin
        ge[l] = rem_in[l] >= {1'b0, den_in[l]};
        if (ge[l]) begin
          rem_nxt[l] = rem_in[l] - {1'b0, den_in[l]};
        end else begin
          rem_nxt[l] = rem_in[l];
        end
        q_nxt[l] = {q_in[l][jvm_pkg::Q_W-2:0], ge[l]};
      end
    end

    assign rdy[k] = !vld_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld_in) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        q_r[k]    <= q_nxt;
        big_r[k]  <= big_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign s_ready = rdy[0];
  assign m_valid = vld_r[NSTEP-1];
  assign quo     = q_r[NSTEP-1];
  assign m_big   = big_r[NSTEP-1];
  assign m_side  = side_r[NSTEP-1];

endmodule

>>> rtl/core/jvm_back.sv
`include "joystick_to_velocity_mapper_defines.svh"

module jvm_back (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            s_valid,
  output logic                                            s_ready,
  input  logic [jvm_pkg::N_LANE-1:0][jvm_pkg::Q_W-1:0]    quo,
  input  logic [jvm_pkg::N_LANE-1:0]                      big,
  input  jvm_pkg::side_t                                  side,
  input  logic [jvm_pkg::SPD_W-1:0]                       max_lin,
  input  logic [jvm_pkg::SPD_W-1:0]                       max_ang,
  output logic                                            m_valid,
  input  logic                                            m_ready,
  output jvm_pkg::vel_t                                   vel
);

  logic signed [jvm_pkg::VEL_W-1:0]                    lin_lim;
  logic signed [jvm_pkg::VEL_W-1:0]                    ang_lim;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::SPD_W-1:0]      spd;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::VEL_W-1:0]      lim;

  // Stage 1: saturated magnitudes
  logic                                                vld1_r;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::Q_W-1:0]        mag1_nxt;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::Q_W-1:0]        mag1_r;
  logic [jvm_pkg::Q_W-1:0]                             db1_nxt;
  logic [jvm_pkg::Q_W-1:0]                             db1_r;
  jvm_pkg::side_t                                      side1_r;

  // Stage 2: squares, speed products, deadband tests
  logic                                                vld2_r;
  logic [jvm_pkg::SQ_W-1:0]                            sqx2_nxt, sqy2_nxt, sqdb2_nxt;
  logic [jvm_pkg::SQ_W-1:0]                            sqx2_r, sqy2_r, sqdb2_r;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::PROD_W-1:0]     prod2_nxt;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::PROD_W-1:0]     prod2_r;
  logic [jvm_pkg::N_AXIS-1:0]                          over2_nxt;
  logic [jvm_pkg::N_AXIS-1:0]                          over2_r;
  jvm_pkg::side_t                                      side2_r;

  // Stage 3: output register
  logic                                                vld3_r;
  logic [jvm_pkg::SQ_W:0]                              r2;
  logic                                                trans_on;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::VEL_W-1:0]      prop;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::VEL_W-1:0]      disc;
  logic [jvm_pkg::N_AXIS-1:0][jvm_pkg::VEL_W-1:0]      res;
  jvm_pkg::vel_t                                       vel_nxt;
  jvm_pkg::vel_t                                       vel_r;
  jvm_pkg::mode_t                                      mode3_r;

  logic                                                rdy1, rdy2, rdy3;

  assign lin_lim = {1'b0, max_lin};
  assign ang_lim = {1'b0, max_ang};

  assign spd[jvm_pkg::LANE_X]   = max_lin;
  assign spd[jvm_pkg::LANE_Y]   = max_lin;
  assign spd[jvm_pkg::LANE_ROT] = max_ang;
  assign lim[jvm_pkg::LANE_X]   = lin_lim;
  assign lim[jvm_pkg::LANE_Y]   = lin_lim;
  assign lim[jvm_pkg::LANE_ROT] = ang_lim;

  assign rdy3    = !vld3_r || m_ready;
  assign rdy2    = !vld2_r || rdy3;
  assign rdy1    = !vld1_r || rdy2;
  assign s_ready = rdy1;

  always_comb begin
    for (int i = 0; i < jvm_pkg::N_AXIS; i++) begin
      if (big[i] || quo[i][jvm_pkg::Q_W-1]) begin
        mag1_nxt[i] = side.neg[i] ? jvm_pkg::Q_ONE : jvm_pkg::Q_MAX;
      end else begin
        mag1_nxt[i] = quo[i];
      end
    end
    db1_nxt = big[jvm_pkg::LANE_DB] ? jvm_pkg::DB_SAT : quo[jvm_pkg::LANE_DB];
  end

  always_comb begin
    sqx2_nxt  = jvm_pkg::SQ_W'(mag1_r[jvm_pkg::LANE_X]) * jvm_pkg::SQ_W'(mag1_r[jvm_pkg::LANE_X]);
    sqy2_nxt  = jvm_pkg::SQ_W'(mag1_r[jvm_pkg::LANE_Y]) * jvm_pkg::SQ_W'(mag1_r[jvm_pkg::LANE_Y]);
    sqdb2_nxt = jvm_pkg::SQ_W'(db1_r) * jvm_pkg::SQ_W'(db1_r);
    for (int i = 0; i < jvm_pkg::N_AXIS; i++) begin
      prod2_nxt[i] = jvm_pkg::PROD_W'(mag1_r[i]) * jvm_pkg::PROD_W'(spd[i]);
      over2_nxt[i] = mag1_r[i] > db1_r;
    end
  end

  always_comb begin
    r2       = {1'b0, sqx2_r} + {1'b0, sqy2_r};
    trans_on = r2 > {1'b0, sqdb2_r};
    for (int i = 0; i < jvm_pkg::N_AXIS; i++) begin
      // Stick below center drives the positive direction
      prop[i] = side2_r.neg[i] ? prod2_r[i][jvm_pkg::PROD_W-1:jvm_pkg::SPD_W]
                               : -prod2_r[i][jvm_pkg::PROD_W-1:jvm_pkg::SPD_W];
      if (over2_r[i]) begin
        disc[i] = side2_r.neg[i] ? lim[i] : -lim[i];
      end else begin
        disc[i] = '0;
      end
    end
    res = '0;
    case (side2_r.mode)
      jvm_pkg::MODE_DISC: res = disc;
      jvm_pkg::MODE_PROP: begin
        if (trans_on) begin
          res[jvm_pkg::LANE_X] = prop[jvm_pkg::LANE_X];
          res[jvm_pkg::LANE_Y] = prop[jvm_pkg::LANE_Y];
        end
        if (over2_r[jvm_pkg::LANE_ROT]) begin
          res[jvm_pkg::LANE_ROT] = prop[jvm_pkg::LANE_ROT];
        end
      end
      default: res = '0;
    endcase
    vel_nxt.vel_forward = res[jvm_pkg::LANE_Y];
    vel_nxt.vel_lateral = res[jvm_pkg::LANE_X];
    vel_nxt.vel_turn    = res[jvm_pkg::LANE_ROT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        vld1_r <= s_valid;
      end
      if (rdy2) begin
        vld2_r <= vld1_r;
      end
      if (rdy3) begin
        vld3_r <= vld2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_valid) begin
      mag1_r  <= mag1_nxt;
      db1_r   <= db1_nxt;
      side1_r <= side;
    end
    if (rdy2 && vld1_r) begin
      sqx2_r  <= sqx2_nxt;
      sqy2_r  <= sqy2_nxt;
      sqdb2_r <= sqdb2_nxt;
      prod2_r <= prod2_nxt;
      over2_r <= over2_nxt;
      side2_r <= side1_r;
    end
    if (rdy3 && vld2_r) begin
      vel_r   <= vel_nxt;
      mode3_r <= side2_r.mode;
    end
  end

  assign m_valid = vld3_r;
  assign vel     = vel_r;

  `JVM_ASSERT_IMP(a_zero_mode, clk, rst_n, vld3_r && (mode3_r == jvm_pkg::MODE_ZERO), vel_r == '0, "nonzero velocity for unknown mode")
  `JVM_ASSERT_IMP(a_fwd_bound, clk, rst_n, vld3_r, (vel_r.vel_forward <= lin_lim) && (vel_r.vel_forward >= -lin_lim), "forward velocity beyond linear limit")
  `JVM_ASSERT_IMP(a_turn_bound, clk, rst_n, vld3_r, (vel_r.vel_turn <= ang_lim) && (vel_r.vel_turn >= -ang_lim), "turn velocity beyond angular limit")
  `JVM_ASSERT_NXT(a_s2_advance, clk, rst_n, vld2_r && rdy3, vld3_r, "stage two item lost on advance")

endmodule
